/* hdl/spc_pkg.sv */
`timescale 1ns / 1ps
package spc_pkg;
    localparam int NORM_FRAC = 14;
    localparam int DF_FRAC = 8;
    localparam logic [15:0] DF_RESET = 16'd256;
    localparam int SQ_W = 68;
    localparam int ROOT_W = 34;
    localparam int DIV_W = 16;
    localparam logic [0:0] REG_DETECT_FACTOR = 1'b0;

    typedef struct packed {
        logic signed [31:0] pa_x;
        logic signed [31:0] pa_y;
        logic signed [31:0] pa_z;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
        logic signed [32:0] d_z;
        logic [31:0]        rsum;
        logic signed [32:0] t;
        logic               hit;
    } spc_item_t;
endpackage

/* hdl/spc_if.sv */
`timescale 1ns / 1ps
interface spc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic [30:0]        radius_a;
    logic [30:0]        radius_b;
    logic               already_real;
    modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                    radius_a, radius_b, already_real, input ready);
    modport sink (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                  radius_a, radius_b, already_real, output ready);
endinterface

interface spc_out_if;
    logic               valid;
    logic               ready;
    logic               in_contact;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] depth;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source (output valid, in_contact, normal_x, normal_y, normal_z, depth,
                    point_x, point_y, point_z, input ready);
    modport sink (input valid, in_contact, normal_x, normal_y, normal_z, depth,
                  point_x, point_y, point_z, output ready);
endinterface

/* hdl/sphere_pair_contact_geometry.sv */
`timescale 1ns / 1ps
// pipeline from input beat to output beat: 3 front stages, 34 root cells, divide setup,
// 16 divide cells, 2 finishing stages; throughput: one pair per cycle while not stalled;
// the pipeline advances whenever the output register is empty or being taken
// rst_n clears all valid flags and sets detect_factor to 1.0 (256)
module sphere_pair_contact_geometry
    import spc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    spc_in_if.sink      in_ch,
    spc_out_if.source   out_ch
);
    localparam int RW = ROOT_W + DIV_W;
    localparam int NS = ROOT_W;
    localparam int ND = DIV_W;

    logic [15:0] detect_factor_reg;
    logic        en;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DETECT_FACTOR) ? {16'd0, detect_factor_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_factor_reg <= DF_RESET;
        end
        else if (psel && penable && pwrite && paddr == REG_DETECT_FACTOR)
        begin
            detect_factor_reg <= pwdata[15:0];
        end
    end

    // front: differences, squares, detection product
    logic        f0_valid_reg;
    spc_item_t   f0_item_reg;
    logic [63:0] f0_sq_reg [3];
    logic [47:0] f0_fr_reg;
    logic        f0_real_reg;
    logic signed [32:0] dd [3];
    logic [31:0] ad [3];
    logic [31:0] rsum_w;

    assign rsum_w = {1'b0, in_ch.radius_a} + {1'b0, in_ch.radius_b};
    assign dd[0] = 33'(in_ch.pos_b_x) - 33'(in_ch.pos_a_x);
    assign dd[1] = 33'(in_ch.pos_b_y) - 33'(in_ch.pos_a_y);
    assign dd[2] = 33'(in_ch.pos_b_z) - 33'(in_ch.pos_a_z);
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ad[k] = dd[k][32] ? 32'(-dd[k]) : dd[k][31:0];
        end
    end

    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f0_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_item_reg.pa_x <= in_ch.pos_a_x;
            f0_item_reg.pa_y <= in_ch.pos_a_y;
            f0_item_reg.pa_z <= in_ch.pos_a_z;
            f0_item_reg.d_x  <= dd[0];
            f0_item_reg.d_y  <= dd[1];
            f0_item_reg.d_z  <= dd[2];
            f0_item_reg.rsum <= rsum_w;
            f0_item_reg.t    <= 33'({1'b0, in_ch.radius_a}) - 33'({1'b0, in_ch.radius_b});
            f0_item_reg.hit  <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                f0_sq_reg[k] <= 64'(ad[k]) * 64'(ad[k]);
            end
            f0_fr_reg   <= 48'(detect_factor_reg) * 48'(rsum_w);
            f0_real_reg <= in_ch.already_real;
        end
    end

    // second front stage: sum of squares and partial products of the detection square
    logic        f1_valid_reg;
    spc_item_t   f1_item_reg;
    logic [SQ_W-1:0] f1_s_reg;
    logic        f1_real_reg;
    logic [63:0] f1_ll_reg;
    logic [47:0] f1_hl_reg;
    logic [31:0] f1_hh_reg;
    logic [SQ_W-1:0] s_w;

    assign s_w = SQ_W'(f0_sq_reg[0]) + SQ_W'(f0_sq_reg[1]) + SQ_W'(f0_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= f0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_item_reg <= f0_item_reg;
            f1_s_reg    <= s_w;
            f1_real_reg <= f0_real_reg;
            f1_ll_reg   <= 64'(f0_fr_reg[31:0]) * 64'(f0_fr_reg[31:0]);
            f1_hl_reg   <= 48'(f0_fr_reg[47:32]) * 48'(f0_fr_reg[31:0]);
            f1_hh_reg   <= 32'(f0_fr_reg[47:32]) * 32'(f0_fr_reg[47:32]);
        end
    end

    // third front stage: detection compare
    logic        f2_valid_reg;
    spc_item_t   f2_item_reg;
    logic [SQ_W-1:0] f2_s_reg;
    logic [95:0] lhs_w;
    spc_item_t   f2_item_w;

    assign lhs_w = (96'(f1_hh_reg) << 64) + (96'(f1_hl_reg) << 33) + 96'(f1_ll_reg);

    always_comb
    begin
        f2_item_w = f1_item_reg;
        f2_item_w.hit = f1_real_reg || (lhs_w > ({28'd0, f1_s_reg} << (2 * DF_FRAC)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_item_reg <= f2_item_w;
            f2_s_reg    <= f1_s_reg;
        end
    end

    // square root chain
    logic              sv   [NS+1];
    logic [SQ_W-1:0]   srem [NS+1];
    logic [ROOT_W-1:0] sroot[NS+1];
    spc_item_t         sitem[NS+1];

    assign sv[0]    = f2_valid_reg;
    assign srem[0]  = f2_s_reg;
    assign sroot[0] = '0;
    assign sitem[0] = f2_item_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_sqrt
        spc_sqrt_cell #(.BIT(NS - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sv[g]),
            .in_rem    (srem[g]),
            .in_root   (sroot[g]),
            .in_item   (sitem[g]),
            .out_valid (sv[g+1]),
            .out_rem   (srem[g+1]),
            .out_root  (sroot[g+1]),
            .out_item  (sitem[g+1])
        );
    end

    // divide setup: numerator (|d|<<14) + len/2
    logic              dv_reg;
    spc_item_t         ditem_reg;
    logic [ROOT_W-1:0] dlen_reg;
    logic [3*RW-1:0]   dnum_reg;
    logic [32:0]       adn [3];

    always_comb
    begin
        adn[0] = sitem[NS].d_x[32] ? 33'(-sitem[NS].d_x) : sitem[NS].d_x;
        adn[1] = sitem[NS].d_y[32] ? 33'(-sitem[NS].d_y) : sitem[NS].d_y;
        adn[2] = sitem[NS].d_z[32] ? 33'(-sitem[NS].d_z) : sitem[NS].d_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg <= sv[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ditem_reg <= sitem[NS];
            dlen_reg  <= sroot[NS];
            for (int k = 0; k < 3; k++)
            begin
                dnum_reg[k*RW +: RW] <= (RW'(adn[k]) << NORM_FRAC) + RW'(sroot[NS] >> 1);
            end
        end
    end

    // divide chain, item data rides in a shift line beside it
    logic [3*RW-1:0]    drem [ND+1];
    logic [3*DIV_W-1:0] dq   [ND+1];
    logic               dvl  [ND+1];
    spc_item_t          dit  [ND+1];
    logic [ROOT_W-1:0]  dln  [ND+1];

    assign drem[0] = dnum_reg;
    assign dq[0]   = '0;
    assign dvl[0]  = dv_reg;
    assign dit[0]  = ditem_reg;
    assign dln[0]  = dlen_reg;

    for (genvar g = 0; g < ND; g++)
    begin : g_div
        logic              v_reg;
        spc_item_t         it_reg;
        logic [ROOT_W-1:0] ln_reg;

        spc_div_cell #(.BIT(ND - 1 - g)) u_cell (
            .clk     (clk),
            .en      (en),
            .len     (dln[g]),
            .in_rem  (drem[g]),
            .in_q    (dq[g]),
            .out_rem (drem[g+1]),
            .out_q   (dq[g+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= dvl[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_reg <= dit[g];
                ln_reg <= dln[g];
            end
        end

        assign dvl[g+1] = v_reg;
        assign dit[g+1] = it_reg;
        assign dln[g+1] = ln_reg;
    end

    // finish stage 1: normals, |t|*q, depth
    logic              e1_valid_reg;
    spc_item_t         e1_item_reg;
    logic signed [15:0] e1_n_reg [3];
    logic [49:0]       e1_m_reg [3];
    logic signed [31:0] e1_depth_reg;
    logic              e1_tneg_reg;
    logic [DIV_W-1:0]  qk [3];
    logic signed [32:0] dk [3];
    logic signed [34:0] t_w;
    logic [33:0]       at_w;
    logic signed [34:0] depth_w;

    assign dk[0] = dit[ND].d_x;
    assign dk[1] = dit[ND].d_y;
    assign dk[2] = dit[ND].d_z;
    // t = radius_a - radius_b + len
    assign t_w = 35'(dit[ND].t) + {1'b0, dln[ND]};
    assign at_w = t_w[34] ? 34'(-t_w) : t_w[33:0];
    assign depth_w = 35'({1'b0, dit[ND].rsum}) - 35'({1'b0, dln[ND]});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qk[k] = (dln[ND] == '0) ? '0 : dq[ND][k*DIV_W +: DIV_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_valid_reg <= dvl[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_item_reg <= dit[ND];
            e1_tneg_reg <= t_w[34];
            for (int k = 0; k < 3; k++)
            begin
                e1_n_reg[k] <= dk[k][32] ? -$signed(qk[k]) : $signed(qk[k]);
                e1_m_reg[k] <= 50'(at_w) * 50'(qk[k]);
            end
            if (depth_w > 35'sd2147483647)
            begin
                e1_depth_reg <= 32'sh7fffffff;
            end
            else if (depth_w < -35'sd2147483648)
            begin
                e1_depth_reg <= 32'sh80000000;
            end
            else
            begin
                e1_depth_reg <= depth_w[31:0];
            end
        end
    end

    // finish stage 2: offset, point, saturation, blanking
    logic signed [35:0] pt [3];
    logic signed [31:0] pts [3];
    logic [34:0]        mm [3];
    logic signed [31:0] pa_k [3];

    assign pa_k[0] = e1_item_reg.pa_x;
    assign pa_k[1] = e1_item_reg.pa_y;
    assign pa_k[2] = e1_item_reg.pa_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mm[k] = 35'((e1_m_reg[k] + (50'd1 << NORM_FRAC)) >> (NORM_FRAC + 1));
            if (e1_tneg_reg != e1_n_reg[k][15])
            begin
                pt[k] = 36'(pa_k[k]) - 36'(mm[k]);
            end
            else
            begin
                pt[k] = 36'(pa_k[k]) + 36'(mm[k]);
            end
            if (pt[k] > 36'sd2147483647)
            begin
                pts[k] = 32'sh7fffffff;
            end
            else if (pt[k] < -36'sd2147483648)
            begin
                pts[k] = 32'sh80000000;
            end
            else
            begin
                pts[k] = pt[k][31:0];
            end
        end
    end

    logic        o_valid_reg;
    logic        o_hit_reg;
    logic signed [15:0] o_n_reg [3];
    logic signed [31:0] o_depth_reg;
    logic signed [31:0] o_pt_reg [3];
    logic        hit_w;

    // sign of normal equals sign of d when q nonzero; q zero gives zero offset anyway
    assign hit_w = e1_item_reg.hit;
    assign en = !o_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_hit_reg   <= hit_w;
            o_depth_reg <= hit_w ? e1_depth_reg : '0;
            for (int k = 0; k < 3; k++)
            begin
                o_n_reg[k]  <= hit_w ? e1_n_reg[k] : '0;
                o_pt_reg[k] <= hit_w ? pts[k] : '0;
            end
        end
    end

    assign out_ch.valid      = o_valid_reg;
    assign out_ch.in_contact = o_hit_reg;
    assign out_ch.normal_x   = o_n_reg[0];
    assign out_ch.normal_y   = o_n_reg[1];
    assign out_ch.normal_z   = o_n_reg[2];
    assign out_ch.depth      = o_depth_reg;
    assign out_ch.point_x    = o_pt_reg[0];
    assign out_ch.point_y    = o_pt_reg[1];
    assign out_ch.point_z    = o_pt_reg[2];

    logic unused_frac;
    assign unused_frac = (FRAC_BITS > 0);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.depth))
        else $error("output beat dropped");
    a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.in_contact |-> out_ch.depth == 0 && out_ch.normal_x == 0)
        else $error("no contact but fields set");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(e1_valid_reg))
        else $error("pipeline moved during stall");
endmodule

/* hdl/spc_sqrt_cell.sv */
`timescale 1ns / 1ps
module spc_sqrt_cell
    import spc_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SQ_W-1:0]      in_rem,
    input  logic [ROOT_W-1:0]    in_root,
    input  spc_item_t            in_item,
    output logic                 out_valid,
    output logic [SQ_W-1:0]      out_rem,
    output logic [ROOT_W-1:0]    out_root,
    output spc_item_t            out_item
);
    // restoring square root, one result bit per cell
    logic [SQ_W+1:0] trial;
    logic            take;
    logic [SQ_W+1:0] sub_res;
    logic            valid_reg;
    logic [SQ_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    spc_item_t       item_reg;

    assign trial = ({{(SQ_W+2-ROOT_W){1'b0}}, in_root} << (BIT + 1))
                 + ((SQ_W+2)'(1) << (2 * BIT));
    assign take = {2'b00, in_rem} >= trial;
    assign sub_res = {2'b00, in_rem} - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= take ? sub_res[SQ_W-1:0] : in_rem;
            root_reg <= take ? (in_root | (ROOT_W'(1) << BIT)) : in_root;
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_item  = item_reg;
endmodule

/* hdl/spc_div_cell.sv */
`timescale 1ns / 1ps
module spc_div_cell
    import spc_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [ROOT_W-1:0] len,
    input  logic [3*(ROOT_W+DIV_W)-1:0] in_rem,
    input  logic [3*DIV_W-1:0] in_q,
    output logic [3*(ROOT_W+DIV_W)-1:0] out_rem,
    output logic [3*DIV_W-1:0] out_q
);
    // one quotient bit for three lanes of restoring division
    localparam int RW = ROOT_W + DIV_W;
    logic [3*RW-1:0]    rem_next;
    logic [3*DIV_W-1:0] q_next;
    logic [3*RW-1:0]    rem_reg;
    logic [3*DIV_W-1:0] q_reg;
    logic [RW+DIV_W-1:0] sh;

    always_comb
    begin
        rem_next = in_rem;
        q_next = in_q;
        sh = '0;
        for (int k = 0; k < 3; k++)
        begin
            sh = {{DIV_W{1'b0}}, len} << BIT;
            if ({{DIV_W{1'b0}}, in_rem[k*RW +: RW]} >= sh)
            begin
                rem_next[k*RW +: RW] = in_rem[k*RW +: RW] - sh[RW-1:0];
                q_next[k*DIV_W + BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign out_rem = rem_reg;
    assign out_q   = q_reg;
endmodule

/* sim/tb_sphere_pair_contact_geometry.sv */
`timescale 1ns / 1ps
module tb_sphere_pair_contact_geometry;
    import spc_pkg::*;

    typedef struct {
        logic               in_contact;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] depth;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } contact_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spc_in_if  in_ch ();
    spc_out_if out_ch ();

    sphere_pair_contact_geometry uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.source),
        .out_ch  (out_ch.sink)
    );

    contact_t    expected_contacts[$];
    logic [15:0] detect_factor;
    int          error_count;
    int          idle_pct;
    int          results_seen;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [67:0] root_floor(input logic [67:0] s);
        logic [67:0] r;
        logic [67:0] c;
        r = '0;
        for (int i = 33; i >= 0; i--)
        begin
            c = r | (68'd1 << i);
            if (c * c <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic contact_t predict_contact(
        input logic signed [31:0] ax, ay, az, bx, by, bz,
        input logic [30:0] ra, rb, input logic real_flag);
        contact_t c;
        logic signed [33:0] pa[3];
        logic signed [33:0] d[3];
        logic [32:0]  ad;
        logic [67:0]  sq;
        logic [95:0]  scaled;
        logic [95:0]  lhs;
        logic [67:0]  len;
        logic signed [70:0] depth_w;
        logic signed [70:0] t;
        logic [70:0]  at;
        logic [70:0]  q;
        logic [95:0]  m;
        logic signed [95:0] off;
        logic signed [95:0] pt;
        logic signed [15:0] n[3];
        logic signed [31:0] p[3];
        c = '{default: '0};
        pa[0] = ax; pa[1] = ay; pa[2] = az;
        d[0] = bx - pa[0]; d[1] = by - pa[1]; d[2] = bz - pa[2];
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            ad = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            sq += 68'(ad) * 68'(ad);
        end
        scaled = 96'(detect_factor) * (96'(ra) + 96'(rb));
        lhs = scaled * scaled;
        if (!(lhs > (96'(sq) << (2 * DF_FRAC))) && !real_flag)
            return c;
        len = root_floor(sq);
        depth_w = 71'(ra) + 71'(rb) - 71'(len);
        t = 71'(ra) - 71'(rb) + 71'(len);
        at = t < 0 ? 71'(-t) : 71'(t);
        for (int i = 0; i < 3; i++)
        begin
            ad = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            q = '0;
            if (len != 0)
                q = ((71'(ad) << NORM_FRAC) + 71'(len >> 1)) / 71'(len);
            n[i] = d[i] < 0 ? -16'(q) : 16'(q);
            m = (96'(at) * 96'(q) + (96'd1 << NORM_FRAC)) >> (NORM_FRAC + 1);
            off = ((t < 0) != (d[i] < 0)) ? -$signed(m) : $signed(m);
            pt = 96'(pa[i]) + off;
            if (pt > 96'sd2147483647)
                p[i] = 32'h7fffffff;
            else if (pt < -96'sd2147483648)
                p[i] = 32'h80000000;
            else
                p[i] = pt[31:0];
        end
        c.in_contact = 1'b1;
        c.normal_x = n[0]; c.normal_y = n[1]; c.normal_z = n[2];
        if (depth_w > 71'sd2147483647)
            c.depth = 32'h7fffffff;
        else if (depth_w < -71'sd2147483648)
            c.depth = 32'h80000000;
        else
            c.depth = depth_w[31:0];
        c.point_x = p[0]; c.point_y = p[1]; c.point_z = p[2];
        return c;
    endfunction

    task automatic write_detect_factor(input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_DETECT_FACTOR; pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        detect_factor = value;
    endtask

    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (expected_contacts.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic send_pair(
        input logic signed [31:0] ax, ay, az, bx, by, bz,
        input logic [30:0] ra, rb, input logic real_flag);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pos_a_x <= ax; in_ch.pos_a_y <= ay; in_ch.pos_a_z <= az;
        in_ch.pos_b_x <= bx; in_ch.pos_b_y <= by; in_ch.pos_b_z <= bz;
        in_ch.radius_a <= ra; in_ch.radius_b <= rb; in_ch.already_real <= real_flag;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_contacts.push_back(predict_contact(ax, ay, az, bx, by, bz, ra, rb, real_flag));
    endtask

    task automatic send_random_pair(input int spread);
        logic signed [31:0] ax, ay, az;
        int sel;
        sel = $urandom_range(3);
        if (sel == 0)
            send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      31'($urandom), 31'($urandom), 1'($urandom));
        else
        begin
            ax = $urandom; ay = $urandom; az = $urandom;
            send_pair(ax, ay, az,
                      ax + $signed($urandom_range(2 * spread) - spread),
                      ay + $signed($urandom_range(2 * spread) - spread),
                      az + $signed($urandom_range(2 * spread) - spread),
                      31'($urandom_range(spread)), 31'($urandom_range(spread)),
                      $urandom_range(7) == 0);
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff; mn = 32'sh80000000;
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_pair(100, 200, 300, 100, 200, 300, 65536, 65536, 1'b0);
        send_pair(0, 0, 0, 65536, 0, 0, 65536, 65536, 1'b0);
        send_pair(0, 0, 0, 0, -131072, 0, 65536, 65536, 1'b0);
        send_pair(0, 0, 0, 0, 0, 131072, 65536, 65536, 1'b0);
        send_pair(0, 0, 0, 0, 0, 131073, 65536, 65536, 1'b0);
        send_pair(mn, mn, mn, mx, mx, mx, 31'h7fffffff, 31'h7fffffff, 1'b0);
        send_pair(mx, mx, mx, mn, mn, mn, 31'h7fffffff, 31'h7fffffff, 1'b1);
        send_pair(mx, mn, mx, mn, mx, mn, 0, 31'h7fffffff, 1'b1);
        send_pair(mx, mx, mx, mx, mx, mx, 31'h7fffffff, 31'h7fffffff, 1'b0);
        send_pair(mn, mn, mn, mn, mn, mn, 31'h7fffffff, 0, 1'b1);
        send_pair(0, 0, 0, 1, 1, 1, 0, 0, 1'b1);
        send_pair(-5, 7, -9, 3, -4, 11, 100, 1, 1'b0);
        send_pair(0, 0, 0, 1000000, 0, 0, 10, 10, 1'b1);
        send_pair(0, 0, 0, -300000, 400000, 0, 31'h7fffffff, 0, 1'b0);
    endtask

    task automatic test_detect_factor_settings();
        logic [15:0] settings[4];
        settings = '{16'd0, 16'd65535, 16'd128, 16'd1};
        foreach (settings[k])
        begin
            drain_pipeline();
            write_detect_factor(settings[k]);
            send_pair(0, 0, 0, 65536, 0, 0, 65536, 65536, 1'b0);
            send_pair(0, 0, 0, 65536, 0, 0, 65536, 65536, 1'b1);
            send_pair(0, 0, 0, 0, 0, 0, 1, 0, 1'b0);
            for (int i = 0; i < 60; i++)
                send_random_pair(1 << $urandom_range(8, 30));
        end
        drain_pipeline();
        write_detect_factor(DF_RESET);
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < 500; i++)
        begin
            idle_pct = (i >= 200 && i < 300) ? 0 : 31;
            if (i == 350)
            begin
                in_ch.valid <= 1'b0;
                while (expected_contacts.size() != 0)
                    @(posedge clk);
            end
            send_random_pair(1 << $urandom_range(4, 30));
        end
        idle_pct = 31;
    endtask

    always @(posedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        contact_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_contacts.size() == 0)
            begin
                $error("unexpected result beat");
                error_count++;
            end
            else
            begin
                e = expected_contacts.pop_front();
                if (out_ch.in_contact !== e.in_contact)
                begin
                    $error("in_contact exp %0d got %0d", e.in_contact, out_ch.in_contact);
                    error_count++;
                end
                if (out_ch.normal_x !== e.normal_x)
                begin
                    $error("normal_x exp %0d got %0d", e.normal_x, out_ch.normal_x);
                    error_count++;
                end
                if (out_ch.normal_y !== e.normal_y)
                begin
                    $error("normal_y exp %0d got %0d", e.normal_y, out_ch.normal_y);
                    error_count++;
                end
                if (out_ch.normal_z !== e.normal_z)
                begin
                    $error("normal_z exp %0d got %0d", e.normal_z, out_ch.normal_z);
                    error_count++;
                end
                if (out_ch.depth !== e.depth)
                begin
                    $error("depth exp %0d got %0d", e.depth, out_ch.depth);
                    error_count++;
                end
                if (out_ch.point_x !== e.point_x)
                begin
                    $error("point_x exp %0d got %0d", e.point_x, out_ch.point_x);
                    error_count++;
                end
                if (out_ch.point_y !== e.point_y)
                begin
                    $error("point_y exp %0d got %0d", e.point_y, out_ch.point_y);
                    error_count++;
                end
                if (out_ch.point_z !== e.point_z)
                begin
                    $error("point_z exp %0d got %0d", e.point_z, out_ch.point_z);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.pos_a_x = '0; in_ch.pos_a_y = '0; in_ch.pos_a_z = '0;
        in_ch.pos_b_x = '0; in_ch.pos_b_y = '0; in_ch.pos_b_z = '0;
        in_ch.radius_a = '0; in_ch.radius_b = '0; in_ch.already_real = 1'b0;
        out_ch.ready = 1'b0;
        detect_factor = DF_RESET;
        error_count = 0;
        results_seen = 0;
        idle_pct = 31;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_detect_factor_settings();
        test_random_stream();
        in_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (expected_contacts.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (70) @(posedge clk);
        if (error_count == 0 && expected_contacts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
